/* design/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue: capacity, index
// and count widths, operation codes and the packed transfer payloads.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned DataW    = 32;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] head_value;
    logic [4:0]         count;
    logic               is_empty;
    logic               dropped;
  } out_t;

endpackage

/* design/spq_ram.sv */
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/spq_core.sv */
// ----------------------------------------------------------------------------
// spq_core
// Sequencer for the priority queue. Walks the entry RAM one entry at a time
// (a read state, then a compare state) through a single signed comparator,
// shifting entries on insert and remove, keeping count and a head-entry copy.
// ----------------------------------------------------------------------------
module spq_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  spq_pkg::in_t      in_data_i,
  output logic              in_stall_o,
  output logic              res_valid_o,
  output spq_pkg::out_t     res_o,
  input  logic              res_take_i
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_CMP  = 5'b00100,
    S_PUT  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e                          state_q, state_d;
  logic [1:0]                      kind_q, kind_d;
  logic signed [31:0]              val_q, val_d;
  logic [spq_pkg::IdxW-1:0]        idx_q, idx_d;
  logic [spq_pkg::CntW-1:0]        count_q, count_d;
  logic signed [31:0]              head_q, head_d;
  logic                            drop_q, drop_d;

  logic                            we;
  logic [spq_pkg::IdxW-1:0]        waddr;
  logic [31:0]                     wdata;
  logic [31:0]                     rdata;
  logic                            less;
  logic                            last_pop;

  spq_ram #(
    .Width (spq_pkg::DataW),
    .Depth (spq_pkg::Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // Shared comparator: stored entry strictly below the incoming value.
  assign less     = $signed(rdata) < val_q;
  assign last_pop = (spq_pkg::CntW'(idx_q) + spq_pkg::CntW'(1)) == count_q;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    val_d   = val_q;
    idx_d   = idx_q;
    count_d = count_q;
    head_d  = head_q;
    drop_d  = drop_q;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = rdata;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = in_data_i.kind;
          val_d   = in_data_i.value;
          drop_d  = 1'b0;
          state_d = S_DONE;
          case (in_data_i.kind)
            spq_pkg::KIND_PUSH: begin
              if (count_q == spq_pkg::CntW'(spq_pkg::Capacity)) begin
                drop_d = 1'b1;
              end else if (count_q == '0) begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = in_data_i.value;
                head_d  = in_data_i.value;
                count_d = spq_pkg::CntW'(1);
              end else begin
                idx_d   = spq_pkg::IdxW'(count_q - spq_pkg::CntW'(1));
                state_d = S_READ;
              end
            end
            spq_pkg::KIND_POP: begin
              if (count_q == '0) begin
                drop_d = 1'b1;
              end else if (count_q == spq_pkg::CntW'(1)) begin
                count_d = '0;
              end else begin
                idx_d   = spq_pkg::IdxW'(1);
                state_d = S_READ;
              end
            end
            spq_pkg::KIND_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        we = 1'b1;
        if (kind_q == spq_pkg::KIND_PUSH) begin
          // Walk from the tail: shift smaller entries back one slot.
          waddr = idx_q + spq_pkg::IdxW'(1);
          if (!less) begin
            wdata   = val_q;
            count_d = count_q + spq_pkg::CntW'(1);
            state_d = S_DONE;
          end else if (idx_q == '0) begin
            state_d = S_PUT;
          end else begin
            idx_d   = idx_q - spq_pkg::IdxW'(1);
            state_d = S_READ;
          end
        end else begin
          // Remove: move each entry forward one slot.
          waddr = idx_q - spq_pkg::IdxW'(1);
          if (idx_q == spq_pkg::IdxW'(1)) begin
            head_d = rdata;
          end
          if (last_pop) begin
            count_d = count_q - spq_pkg::CntW'(1);
            state_d = S_DONE;
          end else begin
            idx_d   = idx_q + spq_pkg::IdxW'(1);
            state_d = S_READ;
          end
        end
      end
      S_PUT: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = val_q;
        head_d  = val_q;
        count_d = count_q + spq_pkg::CntW'(1);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    val_q  <= val_d;
    idx_q  <= idx_d;
    head_q <= head_d;
    drop_q <= drop_d;
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.head_value  = (count_q == '0) ? 32'sd0 : head_q;
  assign res_o.count       = 5'(count_q);
  assign res_o.is_empty    = (count_q == '0);
  assign res_o.dropped     = drop_q;

endmodule

/* design/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded max-priority queue of signed 32-bit values kept in descending
// order in a RAM; push, pop head or clear, one status result per operation.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  --------+--------------------------------+------------------------------
//  in      | in_valid_i, in_stall_o         | in_data_i  (kind, value)
//  out     | out_valid_o, out_stall_i       | out_data_o (head_value, count,
//          |                                |   is_empty, dropped)
//
// A push reads back from the tail past every entry smaller than the new
// value, a pop moves every entry behind the head forward, and clear and
// drops skip the walk over the entry RAM with its registered read.
// Reset empties the queue at once; RAM contents need no clearing.
// The result sits in an output register, so a stalled result holds while
// the next operation is already taken in and worked on.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  spq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output spq_pkg::out_t out_data_o
);

  logic          res_valid;
  spq_pkg::out_t res;
  logic          res_take;
  logic          out_valid_q;
  spq_pkg::out_t out_data_q;

  spq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  // Load the output register when it is empty or its transfer completes.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
